// File: rtl/core/rufp_pkg.sv
// Package for the radar serial frame parser: frame constants, defaults
// and the structs passed between the byte checker and the result emitter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rufp_pkg;

  localparam int BUFFER_BYTES_DEF = 64;
  localparam int GATE_COUNT_DEF   = 16;

  localparam logic [31:0] CMD_HEADER  = 32'hFAFB_FCFD;
  localparam logic [31:0] CMD_FOOTER  = 32'h0102_0304;
  localparam logic [31:0] DATA_HEADER = 32'hF1F2_F3F4;
  localparam logic [31:0] DATA_FOOTER = 32'hF5F6_F7F8;

  localparam int MIN_HELD       = 14;  // bytes needed before a header check
  localparam int MIN_ACK        = 14;
  localparam int MIN_DATA       = 43;
  localparam int FRAME_OVERHEAD = 10;
  localparam int FOOTER_BYTES   = 4;
  localparam int GATE_BASE      = 9;   // first energy byte of a data frame

  localparam int TOTAL_W = 17;         // 16-bit length plus overhead, no wrap
  localparam int GUARD_W = 6;          // covers every energy byte address

  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  // frame completion handed from the checker to the emitter
  typedef struct packed {
    logic        ack;
    logic        data;
    logic [15:0] command_word;
    logic [15:0] ack_status;
    logic [5:0]  payload_len;
    logic        presence;
    logic [15:0] distance;
  } rufp_frame_evt_t;

  // emitter status seen by the checker
  typedef struct packed {
    logic               idle;
    logic               res_free;
    logic               guard_on;
    logic [GUARD_W-1:0] guard_addr;  // lowest store byte still to be read
  } rufp_emit_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/rufp_ram.sv
// Generic simple RAM: one write port, two read ports with registered,
// enabled read data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rufp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1,
  output logic      [WIDTH-1:0]         rdata0,
  output logic      [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rufp_frame_check.sv
// Input register, write position, header bytes and footer window; detects
// a complete frame and hands it to the emitter. Uses rufp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rufp_frame_check #(
  parameter int BUFFER_BYTES = rufp_pkg::BUFFER_BYTES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [7:0]                      rx_byte,
  input  wire rufp_pkg::rufp_emit_stat_t       stat,
  output rufp_pkg::rufp_frame_evt_t            evt,
  output logic                                 mem_we,
  output logic [$clog2(BUFFER_BYTES)-1:0]      mem_waddr,
  output logic [7:0]                           mem_wdata
);

  localparam int PW = $clog2(BUFFER_BYTES);
  localparam int TW = rufp_pkg::TOTAL_W;
  localparam int HB = rufp_pkg::MIN_HELD;

  logic          in_full;
  logic [7:0]    in_byte;
  logic [PW-1:0] wpos;
  logic [7:0]    hdr [HB];
  logic [31:0]   last4;

  logic [7:0]    hdr_next [HB];
  logic [31:0]   last4_next;
  logic [PW-1:0] pos_next;
  logic          store;
  logic [31:0]   header;
  logic          is_cmd;
  logic          is_data;
  logic [TW-1:0] total;
  logic          small_total;
  logic [3:0]    foot_idx;
  logic [31:0]   foot_small;
  logic [31:0]   footer;
  logic          at_end;
  logic          complete;
  logic          ack_go;
  logic          data_go;
  logic          wr_ok;
  logic          go;

  always_comb begin
    store = wpos < PW'(BUFFER_BYTES - 1);
    pos_next = store ? wpos + PW'(1) : '0;
    for (int k = 0; k < HB; k++) begin
      hdr_next[k] = (store && wpos == PW'(k)) ? in_byte : hdr[k];
    end
    last4_next = store ? {in_byte, last4[31:8]} : last4;
  end

  always_comb begin
    header  = {hdr_next[3], hdr_next[2], hdr_next[1], hdr_next[0]};
    is_cmd  = header == rufp_pkg::CMD_HEADER;
    is_data = header == rufp_pkg::DATA_HEADER;
    total   = TW'({hdr_next[5], hdr_next[4]}) + TW'(rufp_pkg::FRAME_OVERHEAD);
    small_total = total <= TW'(HB);
    foot_idx = total[3:0] - 4'(rufp_pkg::FOOTER_BYTES);
    // short frames end inside the header registers
    foot_small = '0;
    for (int k = 0; k <= HB - rufp_pkg::FOOTER_BYTES; k++) begin
      if (foot_idx == 4'(k)) begin
        foot_small = {hdr_next[k+3], hdr_next[k+2], hdr_next[k+1], hdr_next[k]};
      end
    end
    footer = small_total ? foot_small : last4_next;
    // the footer is only examined when the position first covers the frame
    at_end = small_total ? (pos_next == PW'(HB)) : (TW'(pos_next) == total);
    complete = store && (pos_next >= PW'(HB)) && at_end &&
               ((is_cmd && footer == rufp_pkg::CMD_FOOTER) ||
                (is_data && footer == rufp_pkg::DATA_FOOTER));
    ack_go  = complete && is_cmd && (total >= TW'(rufp_pkg::MIN_ACK));
    data_go = complete && is_data && (total >= TW'(rufp_pkg::MIN_DATA));
  end

  always_comb begin
    wr_ok = !stat.guard_on || (wpos < PW'(stat.guard_addr));
    if (ack_go) begin
      go = in_full && wr_ok && stat.idle && stat.res_free;
    end else if (data_go) begin
      go = in_full && wr_ok && stat.idle;
    end else begin
      go = in_full && wr_ok;
    end
    in_ready = !in_full || go;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
      wpos    <= '0;
    end else begin
      if (in_ready) begin
        in_full <= in_valid;
      end
      if (go) begin
        wpos <= complete ? '0 : pos_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= rx_byte;
    end
    if (go) begin
      hdr   <= hdr_next;
      last4 <= last4_next;
    end
  end

  assign mem_we    = go && store;
  assign mem_waddr = wpos;
  assign mem_wdata = in_byte;

  always_comb begin
    evt.ack          = go && ack_go;
    evt.data         = go && data_go;
    evt.command_word = {hdr_next[7], hdr_next[6]};
    evt.ack_status   = {hdr_next[9], hdr_next[8]};
    evt.payload_len  = 6'(total - TW'(rufp_pkg::MIN_ACK));
    evt.presence     = hdr_next[6] != 8'd0;
    evt.distance     = {hdr_next[8], hdr_next[7]};
  end

endmodule

`default_nettype wire

// File: rtl/core/rufp_emit.sv
// Result register and gate sequencer: loads acknowledgement results and
// walks the gate energies out of the byte store. Uses rufp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rufp_emit #(
  parameter int BUFFER_BYTES = rufp_pkg::BUFFER_BYTES_DEF,
  parameter int GATE_COUNT   = rufp_pkg::GATE_COUNT_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire rufp_pkg::rufp_frame_evt_t   evt,
  output rufp_pkg::rufp_emit_stat_t        stat,
  output logic                             mem_re,
  output logic [$clog2(BUFFER_BYTES)-1:0]  mem_raddr0,
  output logic [$clog2(BUFFER_BYTES)-1:0]  mem_raddr1,
  input  wire logic [7:0]                  mem_rdata0,
  input  wire logic [7:0]                  mem_rdata1,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             frame_kind,
  output logic [15:0]                      command_word,
  output logic [15:0]                      ack_status,
  output logic [5:0]                       payload_len,
  output logic                             presence,
  output logic [15:0]                      distance,
  output logic [3:0]                       gate_index,
  output logic [15:0]                      gate_energy,
  output logic                             last
);

  localparam int PW = $clog2(BUFFER_BYTES);
  localparam int CW = $clog2(GATE_COUNT + 1);
  localparam int GW = rufp_pkg::GUARD_W;

  logic          issuing;
  logic [CW-1:0] ig;          // next gate to read
  logic          rd_pending;  // store read data waiting for the result register
  logic [3:0]    rd_gate;
  logic          pres_r;
  logic [15:0]   dist_r;

  logic          res_free;
  logic          load;
  logic          issue;
  logic [GW-1:0] ra0;

  always_comb begin
    res_free = !out_valid || out_ready;
    load     = rd_pending && res_free;
    issue    = issuing && (!rd_pending || load);
    ra0      = GW'(rufp_pkg::GATE_BASE) + GW'({ig, 1'b0});
  end

  assign mem_re     = issue;
  assign mem_raddr0 = PW'(ra0);
  assign mem_raddr1 = PW'(ra0 + GW'(1));

  always_comb begin
    stat.idle       = !issuing && !rd_pending;
    stat.res_free   = res_free;
    stat.guard_on   = issuing;
    stat.guard_addr = ra0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing    <= 1'b0;
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (evt.data) begin
        issuing <= 1'b1;
      end else if (issue && ig == CW'(GATE_COUNT - 1)) begin
        issuing <= 1'b0;
      end
      if (issue) begin
        rd_pending <= 1'b1;
      end else if (load) begin
        rd_pending <= 1'b0;
      end
      if (evt.ack || load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (evt.data) begin
      ig     <= '0;
      pres_r <= evt.presence;
      dist_r <= evt.distance;
    end else if (issue) begin
      ig <= ig + CW'(1);
    end
    if (issue) begin
      rd_gate <= 4'(ig);
    end
    if (evt.ack) begin
      frame_kind   <= rufp_pkg::KIND_ACK;
      command_word <= evt.command_word;
      ack_status   <= evt.ack_status;
      payload_len  <= evt.payload_len;
      presence     <= 1'b0;
      distance     <= '0;
      gate_index   <= '0;
      gate_energy  <= '0;
      last         <= 1'b1;
    end else if (load) begin
      frame_kind   <= rufp_pkg::KIND_DATA;
      command_word <= '0;
      ack_status   <= '0;
      payload_len  <= '0;
      presence     <= pres_r;
      distance     <= dist_r;
      gate_index   <= rd_gate;
      gate_energy  <= {mem_rdata1, mem_rdata0};
      last         <= rd_gate == 4'(GATE_COUNT - 1);
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/radar_uart_frame_parser_unit.sv
// Top level of the radar serial frame parser: checker, byte store and
// result emitter. Uses rufp_pkg, rufp_frame_check, rufp_ram, rufp_emit.
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------
//   input    | in_valid / in_ready  | rx_byte
//   output   | out_valid / out_ready| frame_kind .. gate_energy, last
//
// A byte is taken every cycle while in_ready is high; it is registered and then checked.
// An acknowledgement result goes from the input register into the result register;
// a data frame gives one gate result per cycle while out_ready is high, read after
// the last byte from the store, paced by the two-port store read.
// While gates are read out, a byte whose store slot is still unread waits.
// Reset clears the position and all valid flags; the store needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module radar_uart_frame_parser_unit #(
  parameter int BUFFER_BYTES = rufp_pkg::BUFFER_BYTES_DEF,
  parameter int GATE_COUNT   = rufp_pkg::GATE_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             frame_kind,
  output logic [15:0]      command_word,
  output logic [15:0]      ack_status,
  output logic [5:0]       payload_len,
  output logic             presence,
  output logic [15:0]      distance,
  output logic [3:0]       gate_index,
  output logic [15:0]      gate_energy,
  output logic             last
);

  localparam int PW = $clog2(BUFFER_BYTES);

  rufp_pkg::rufp_frame_evt_t evt;
  rufp_pkg::rufp_emit_stat_t stat;

  logic          mem_we;
  logic [PW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [PW-1:0] mem_raddr0;
  logic [PW-1:0] mem_raddr1;
  logic [7:0]    mem_rdata0;
  logic [7:0]    mem_rdata1;

  rufp_frame_check #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_check (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .stat     (stat),
    .evt      (evt),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata)
  );

  rufp_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr0(mem_raddr0),
    .raddr1(mem_raddr1),
    .rdata0(mem_rdata0),
    .rdata1(mem_rdata1)
  );

  rufp_emit #(
    .BUFFER_BYTES(BUFFER_BYTES),
    .GATE_COUNT  (GATE_COUNT)
  ) u_emit (
    .clk         (clk),
    .rst         (rst),
    .evt         (evt),
    .stat        (stat),
    .mem_re      (mem_re),
    .mem_raddr0  (mem_raddr0),
    .mem_raddr1  (mem_raddr1),
    .mem_rdata0  (mem_rdata0),
    .mem_rdata1  (mem_rdata1),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .frame_kind  (frame_kind),
    .command_word(command_word),
    .ack_status  (ack_status),
    .payload_len (payload_len),
    .presence    (presence),
    .distance    (distance),
    .gate_index  (gate_index),
    .gate_energy (gate_energy),
    .last        (last)
  );

endmodule

`default_nettype wire
